// ===== rtl/saa_pkg.sv =====
// shared types, codes and defaults for the stack arena allocator
package saa_pkg;

   localparam int DATA_W = 32;
   localparam int PAD_W = 15;
   localparam int CSR_ADDR_W = 3;

   localparam int DEF_MAX_FRAMES = 64;
   localparam int DEF_FRAME_BYTES = 16;
   localparam int DEF_ADDR_BITS = 32;

   localparam logic [0:0] REG_ARENA_BASE = 1'b0;
   localparam logic [0:0] REG_ARENA_BYTES = 1'b1;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NOMEM     = 3'd1,
      STATUS_ALIEN     = 3'd2,
      STATUS_UNDERFLOW = 3'd3,
      STATUS_NOTLIFO   = 3'd4,
      STATUS_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_EXEC   = 2'd1,
      S_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      op_type              operation;
      logic [DATA_W-1:0]   alloc_size;
      logic [3:0]          align_log2;
      logic [DATA_W-1:0]   block_address;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   result_address;
      status_type          status;
      logic [DATA_W-1:0]   free_bytes_left;
   } rsp_type;

endpackage

// ===== rtl/stack_arena_allocator_unit.sv =====
// Stack arena allocator: last-in-first-out allocation over a configured byte arena.
// Each transaction runs as follows: the accept edge reads the top frame from the
// frame memory (the read data is registered), the next cycle checks and updates the
// top pointer and frame stack, and the last cycle recomputes the free space. The
// result is shown on rsp_item for exactly one cycle with rsp_strobe, and the next
// start is accepted in that same cycle; busy is high until then, so transactions
// do not overlap. The receiver cannot stall. Writing either arena register restarts the
// allocator with an empty frame stack; write them only while busy is low.
module stack_arena_allocator_unit import saa_pkg::*; #(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES,
   parameter int FRAME_BYTES = DEF_FRAME_BYTES,
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_item,
   output logic                   rsp_strobe,
   output rsp_type                rsp_item,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]      pwdata,
   output logic [DATA_W-1:0]      prdata,
   output logic                   pready
);

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int CW = (ADDR_BITS > DATA_W) ? ADDR_BITS : DATA_W;
   localparam int FW = 2 * ADDR_BITS;
   localparam int CHG_W = DATA_W + 2;

   state_type               state_ff, state_in;
   req_type                 req_ff;
   logic [DATA_W-1:0]       base_ff, base_in;
   logic [DATA_W-1:0]       bytes_ff, bytes_in;
   logic [ADDR_BITS-1:0]    top_ff, top_in;
   logic [DATA_W-1:0]       free_ff, free_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   status_type              status_ff, status_in;
   logic [ADDR_BITS-1:0]    addr_ff, addr_in;
   rsp_type                 rsp_ff;
   logic                    rsp_strobe_ff;

   logic                    req_fire;
   logic                    exec_en;
   logic                    finish_en;
   logic                    cfg_we;
   logic [0:0]              cfg_idx;

   logic [IDX_W-1:0]        rd_idx;
   logic [FW-1:0]           ram_rdata;
   logic                    ram_we;
   logic [FW-1:0]           ram_wdata;
   logic [ADDR_BITS-1:0]    frame_old_top;
   logic [ADDR_BITS-1:0]    frame_block;

   logic [ADDR_BITS-1:0]    base_a;
   logic [PAD_W-1:0]        top_low;
   logic [PAD_W:0]          amask_wide;
   logic [PAD_W-1:0]        pad;
   logic [ADDR_BITS-1:0]    aligned;
   logic [CHG_W-1:0]        charge;
   logic [ADDR_BITS-1:0]    alloc_top;
   logic [ADDR_BITS-1:0]    blk;
   logic [ADDR_BITS-1:0]    off;
   status_type              exec_status;
   logic                    exec_ok;
   logic [ADDR_BITS-1:0]    used;
   logic [DATA_W-1:0]       space;

   // ---------------- handshake and control ----------------

   assign req_fire = start && (state_ff == S_IDLE);
   assign cfg_we = psel && penable && pwrite && pready;
   assign cfg_idx = paddr[CSR_ADDR_W-1];
   assign pready = 1'b1;
   assign prdata = (cfg_idx == REG_ARENA_BYTES) ? bytes_ff : base_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC:   state_in = S_FINISH;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy = 1'b1;
      exec_en = 1'b0;
      finish_en = 1'b0;
      case (state_ff)
         S_IDLE:   busy = 1'b0;
         S_EXEC:   exec_en = 1'b1;
         S_FINISH: finish_en = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

   // ---------------- frame memory ----------------

   // top frame is read on the accept edge; a push from the previous transaction is already written by then
   assign rd_idx = (count_ff == '0) ? '0 : IDX_W'(count_ff - 1'b1);
   assign ram_we = exec_en && exec_ok && (req_ff.operation == OP_ALLOC) && !cfg_we;
   assign ram_wdata = {top_ff, aligned};
   assign frame_old_top = ram_rdata[FW-1:ADDR_BITS];
   assign frame_block = ram_rdata[ADDR_BITS-1:0];

   saa_ram #(
      .WIDTH (FW),
      .DEPTH (MAX_FRAMES)
   ) u_frames (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IDX_W'(count_ff)),
      .wr_data (ram_wdata),
      .rd_en   (req_fire),
      .rd_addr (rd_idx),
      .rd_data (ram_rdata)
   );

   // ---------------- execute ----------------

   assign base_a = ADDR_BITS'(base_ff);
   assign top_low = PAD_W'(top_ff);
   assign amask_wide = ({{PAD_W{1'b0}}, 1'b1} << req_ff.align_log2) - 1'b1;
   // padding comes from the low bits of the negated top
   assign pad = (-top_low) & amask_wide[PAD_W-1:0];
   assign aligned = top_ff + ADDR_BITS'(pad);
   assign charge = CHG_W'(req_ff.alloc_size) + CHG_W'(pad) + CHG_W'(FRAME_BYTES);
   assign alloc_top = top_ff + ADDR_BITS'(charge);
   assign blk = ADDR_BITS'(req_ff.block_address);
   assign off = blk - base_a;

   always_comb begin
      exec_status = STATUS_OK;
      if (req_ff.operation == OP_ALLOC) begin
         if (charge > CHG_W'(free_ff)) begin
            exec_status = STATUS_NOMEM;
         end else if (count_ff >= CNT_W'(MAX_FRAMES)) begin
            exec_status = STATUS_FULL;
         end
      end else begin
         if (CW'(off) >= CW'(bytes_ff)) begin
            exec_status = STATUS_ALIEN;
         end else if (count_ff == '0) begin
            exec_status = STATUS_UNDERFLOW;
         end else if (frame_block != blk) begin
            exec_status = STATUS_NOTLIFO;
         end
      end
   end

   assign exec_ok = (exec_status == STATUS_OK);

   // ---------------- free space ----------------

   assign used = top_ff - base_a;
   assign space = (CW'(used) > CW'(bytes_ff)) ? '0 : DATA_W'(CW'(bytes_ff) - CW'(used));

   // ---------------- state update ----------------

   always_comb begin
      base_in = base_ff;
      bytes_in = bytes_ff;
      top_in = top_ff;
      free_in = free_ff;
      count_in = count_ff;
      status_in = status_ff;
      addr_in = addr_ff;
      if (cfg_we) begin
         if (cfg_idx == REG_ARENA_BASE) begin
            base_in = pwdata;
         end else begin
            bytes_in = pwdata;
         end
         // any register write restarts the arena
         top_in = ADDR_BITS'(base_in);
         free_in = bytes_in;
         count_in = '0;
      end else if (exec_en) begin
         status_in = exec_status;
         addr_in = '0;
         if (exec_ok) begin
            if (req_ff.operation == OP_ALLOC) begin
               top_in = alloc_top;
               count_in = count_ff + 1'b1;
               addr_in = aligned;
            end else begin
               top_in = frame_old_top;
               count_in = count_ff - 1'b1;
            end
         end
      end else if (finish_en) begin
         free_in = space;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff <= '0;
         bytes_ff <= '0;
         top_ff <= '0;
         free_ff <= '0;
         count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         bytes_ff <= bytes_in;
         top_ff <= top_in;
         free_ff <= free_in;
         count_ff <= count_in;
         rsp_strobe_ff <= finish_en;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_item;
      end
      status_ff <= status_in;
      addr_ff <= addr_in;
      if (finish_en) begin
         rsp_ff.result_address <= DATA_W'(addr_ff);
         rsp_ff.status <= status_ff;
         rsp_ff.free_bytes_left <= space;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

   // ---------------- assertions ----------------

   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_FINISH))
      else $error("result strobe without a finishing transaction");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAMES))
      else $error("frame count beyond frame memory depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (exec_en && exec_ok && req_ff.operation == OP_ALLOC && !cfg_we)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("successful allocate did not push a frame");

   a_error_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (exec_en && !exec_ok && !cfg_we) |=> ($stable(top_ff) && $stable(count_ff)))
      else $error("failed transaction changed the allocator state");

   a_error_zero_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != STATUS_OK) |-> rsp_item.result_address == '0)
      else $error("failed transaction returned an address");

endmodule

// ===== rtl/saa_ram.sv =====
// generic single-write, single-read ram with registered read data
module saa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
